### sv/decimal_text_to_integer_macros.svh
// Assertion helpers for the decimal_text_to_integer RTL file.
`ifndef DECIMAL_TEXT_TO_INTEGER_MACROS_SVH
`define DECIMAL_TEXT_TO_INTEGER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DTTI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DTTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dtti_pkg.sv
package dtti_pkg;

    localparam int DTTI_MAX_TEXT_LENGTH = 256;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int STOP_W  = 9;
    localparam int MODE_W  = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;

    // Parse phases.
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_FAIL   = 2'd3;

    // Range check modes.
    localparam logic [MODE_W-1:0] RANGE_S64 = 2'd0;
    localparam logic [MODE_W-1:0] RANGE_S32 = 2'd1;
    localparam logic [MODE_W-1:0] RANGE_U32 = 2'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'd7;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    // Largest magnitudes that may still be multiplied by ten.
    localparam logic signed [VALUE_W-1:0] ACC_POS_LIMIT = 64'sd922337203685477580;
    localparam logic signed [VALUE_W-1:0] ACC_NEG_LIMIT = -64'sd922337203685477580;
    localparam logic [3:0] POS_LAST_DIGIT = 4'd7;
    localparam logic [3:0] NEG_LAST_DIGIT = 4'd8;

    typedef struct packed {
        logic [1:0]                 phase;
        logic                       sign_negative;
        logic signed [VALUE_W-1:0]  accumulator;
    } dtti_core_t;

endpackage

### sv/dtti_step.sv
module dtti_step (
    input  dtti_pkg::dtti_core_t         core_in,
    input  logic [dtti_pkg::CHAR_W-1:0]  char_in,
    output dtti_pkg::dtti_core_t         core_out,
    output logic                         stop_here
);

    logic                                 is_digit;
    logic [3:0]                           digit;
    logic signed [dtti_pkg::VALUE_W-1:0]  digit_ext;
    logic signed [dtti_pkg::VALUE_W-1:0]  acc_times_ten;
    logic [1:0]                           phase_mid;
    logic                                 overflow;

    assign is_digit  = (char_in >= dtti_pkg::CH_ZERO) && (char_in <= dtti_pkg::CH_NINE);
    assign digit     = 4'(char_in - dtti_pkg::CH_ZERO);
    assign digit_ext = {{(dtti_pkg::VALUE_W-4){1'b0}}, digit};
    assign acc_times_ten = (core_in.accumulator <<< 3) + (core_in.accumulator <<< 1);

    assign overflow = (core_in.accumulator > dtti_pkg::ACC_POS_LIMIT) ||
                      ((core_in.accumulator == dtti_pkg::ACC_POS_LIMIT) &&
                       (digit > dtti_pkg::POS_LAST_DIGIT)) ||
                      (core_in.accumulator < dtti_pkg::ACC_NEG_LIMIT) ||
                      ((core_in.accumulator == dtti_pkg::ACC_NEG_LIMIT) &&
                       (digit > dtti_pkg::NEG_LAST_DIGIT));

    always_comb begin
        core_out  = core_in;
        stop_here = 1'b0;
        phase_mid = core_in.phase;

        // The first digit enters the digit phase and is taken in the same step.
        if (core_in.phase == dtti_pkg::PH_PREFIX) begin
            if (is_digit) begin
                phase_mid = dtti_pkg::PH_DIGITS;
            end else begin
                case (char_in) inside
                    dtti_pkg::CH_SPACE, dtti_pkg::CH_TAB, dtti_pkg::CH_CR,
                    dtti_pkg::CH_LF, dtti_pkg::CH_VT, dtti_pkg::CH_FF,
                    dtti_pkg::CH_BEL, dtti_pkg::CH_PLUS: begin
                    end
                    dtti_pkg::CH_MINUS: begin
                        core_out.sign_negative = !core_in.sign_negative;
                    end
                    default: begin
                        phase_mid = dtti_pkg::PH_FAIL;
                        stop_here = 1'b1;
                    end
                endcase
            end
        end

        core_out.phase = phase_mid;
        if (phase_mid == dtti_pkg::PH_DIGITS) begin
            if (!is_digit) begin
                core_out.phase = dtti_pkg::PH_DONE;
                stop_here      = 1'b1;
            end else if (overflow) begin
                core_out.phase = dtti_pkg::PH_FAIL;
                stop_here      = 1'b1;
            end else if (core_in.sign_negative) begin
                core_out.accumulator = acc_times_ten - digit_ext;
            end else begin
                core_out.accumulator = acc_times_ten + digit_ext;
            end
        end
    end

endmodule

### sv/decimal_text_to_integer.sv
// Decimal text to signed 64-bit integer parser.
// Text enters one character per transfer on the s_ channel: s_tdata carries the
// character, and s_tlast set marks the end-of-text item whose character is ignored.
// Leading whitespace, BEL and '+' are skipped, each '-' flips the sign, digits build
// the value, and the first other character ends the parse.
// Each end-of-text item produces exactly one result transfer on the m_ channel:
// the value, the ok flag on m_tuser and the stop position. Other items produce none.
// The cfg_ channel writes the range mode; the user must see that it is written only
// while the block is idle, as the block itself does not enforce it. Throughput is one
// item per cycle while s_tready is high. The result of an end item goes from the
// input register through the result logic, which reads the parse state left by the
// preceding characters, into the result register. When the receiver stalls with a
// result pending, characters keep flowing; the next end item waits in the input
// register and s_tready drops until the result register is taken.
// Reset (synchronous, active low) clears the parse state, the range mode and both
// registers' valid flags.
`include "decimal_text_to_integer_macros.svh"

module decimal_text_to_integer #(
    parameter int MAX_TEXT_LENGTH = dtti_pkg::DTTI_MAX_TEXT_LENGTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dtti_pkg::MODE_W-1:0]      cfg_data,     // range_mode
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dtti_pkg::S_TDATA_W-1:0]   s_tdata,      // [7:0] character
    input  logic                             s_tlast,      // end_of_text
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dtti_pkg::M_TDATA_W-1:0]   m_tdata,      // [63:0] value, [72:64] stop_position
    output logic                             m_tuser       // ok
);

    localparam int IDX_W = $clog2(MAX_TEXT_LENGTH + 1);
    localparam logic [IDX_W-1:0] MaxIdx = IDX_W'(MAX_TEXT_LENGTH);

    logic [dtti_pkg::MODE_W-1:0]           range_mode_reg;

    logic                                  in_valid_reg;
    logic [dtti_pkg::CHAR_W-1:0]           in_char_reg;
    logic                                  in_end_reg;

    dtti_pkg::dtti_core_t                  core_reg;
    dtti_pkg::dtti_core_t                  core_step;
    logic                                  stop_here;
    logic [IDX_W-1:0]                      char_index_reg;
    logic [IDX_W-1:0]                      stop_index_reg;

    logic                                  m_valid_reg;
    logic signed [dtti_pkg::VALUE_W-1:0]   value_reg;
    logic                                  ok_reg;
    logic [dtti_pkg::STOP_W-1:0]           stop_pos_reg;

    logic                                  out_free;
    logic                                  stage_go;
    logic                                  active;

    logic                                  res_ok_next;
    logic                                  range_ok;
    logic [IDX_W-1:0]                      res_pos;
    logic [IDX_W+dtti_pkg::STOP_W-1:0]     res_pos_ext;
    logic signed [dtti_pkg::VALUE_W-1:0]   value_next;

    assign cfg_ready = 1'b1;

    // An end item may only leave the input register when the result register can take it.
    assign out_free = !m_valid_reg || m_tready;
    assign stage_go = in_valid_reg && (!in_end_reg || out_free);
    assign s_tready = !in_valid_reg || stage_go;
    assign active   = (core_reg.phase == dtti_pkg::PH_PREFIX) ||
                      (core_reg.phase == dtti_pkg::PH_DIGITS);

    dtti_step u_step (
        .core_in   (core_reg),
        .char_in   (in_char_reg),
        .core_out  (core_step),
        .stop_here (stop_here)
    );

    // Result of an end item.
    always_comb begin
        unique case (core_reg.phase)
            dtti_pkg::PH_PREFIX: begin
                res_ok_next = 1'b0;
                res_pos     = char_index_reg;
            end
            dtti_pkg::PH_DIGITS: begin
                res_ok_next = 1'b1;
                res_pos     = char_index_reg;
            end
            dtti_pkg::PH_DONE: begin
                res_ok_next = 1'b1;
                res_pos     = stop_index_reg;
            end
            default: begin
                res_ok_next = 1'b0;
                res_pos     = stop_index_reg;
            end
        endcase

        unique case (range_mode_reg)
            dtti_pkg::RANGE_S32: range_ok = (core_reg.accumulator[63:31] == '0) ||
                                            (core_reg.accumulator[63:31] == '1);
            dtti_pkg::RANGE_U32: range_ok = (core_reg.accumulator[63:32] == '0);
            default:             range_ok = 1'b1;
        endcase

        res_ok_next = res_ok_next && range_ok;
        value_next  = res_ok_next ? core_reg.accumulator : '0;
        res_pos_ext = {{dtti_pkg::STOP_W{1'b0}}, res_pos};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_mode_reg <= dtti_pkg::RANGE_S64;
        end else if (cfg_valid && cfg_ready) begin
            range_mode_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata[dtti_pkg::CHAR_W-1:0];
            in_end_reg  <= s_tlast;
        end
    end

    // Parse state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_reg       <= '{phase: dtti_pkg::PH_PREFIX, sign_negative: 1'b0,
                                accumulator: '0};
            char_index_reg <= '0;
            stop_index_reg <= '0;
        end else if (stage_go) begin
            if (in_end_reg) begin
                core_reg       <= '{phase: dtti_pkg::PH_PREFIX, sign_negative: 1'b0,
                                    accumulator: '0};
                char_index_reg <= '0;
                stop_index_reg <= '0;
            end else if (active) begin
                core_reg <= core_step;
                if (stop_here) begin
                    stop_index_reg <= char_index_reg;
                end
                if (char_index_reg < MaxIdx) begin
                    char_index_reg <= char_index_reg + 1'b1;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stage_go && in_end_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_go && in_end_reg) begin
            value_reg    <= value_next;
            ok_reg       <= res_ok_next;
            stop_pos_reg <= res_pos_ext[dtti_pkg::STOP_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dtti_pkg::M_TDATA_W-dtti_pkg::VALUE_W-dtti_pkg::STOP_W){1'b0}},
                       stop_pos_reg, value_reg};
    assign m_tuser  = ok_reg;

    `DTTI_ASSERT_NOW(a_fail_value_zero, m_valid_reg && !ok_reg, value_reg == '0, "failed result nonzero")
    `DTTI_ASSERT_NOW(a_prefix_acc_zero, core_reg.phase == dtti_pkg::PH_PREFIX, core_reg.accumulator == '0, "prefix acc nonzero")
    `DTTI_ASSERT_NEXT(a_end_clears, stage_go && in_end_reg, m_valid_reg && core_reg.phase == dtti_pkg::PH_PREFIX && char_index_reg == '0, "end not cleared")
    `DTTI_ASSERT_NOW(a_index_sat, 1'b1, char_index_reg <= MaxIdx && stop_index_reg <= MaxIdx, "index beyond limit")

endmodule
